### sv/cspb_pkg.sv
package cspb_pkg;

  typedef struct packed {
    logic [2:0]  action;
    logic [9:0]  row;
    logic [9:0]  column;
    logic [15:0] position;
  } req_t;

  typedef struct packed {
    logic [16:0] value;
    logic [10:0] matrix_size;
    logic [1:0]  status;
  } rsp_t;

  localparam logic [2:0] ACT_ADD_STATIC  = 3'd0;
  localparam logic [2:0] ACT_ADD_DYNAMIC = 3'd1;
  localparam logic [2:0] ACT_CLR_STATIC  = 3'd2;
  localparam logic [2:0] ACT_CLR_DYNAMIC = 3'd3;
  localparam logic [2:0] ACT_BUILD       = 3'd4;
  localparam logic [2:0] ACT_OFFSET      = 3'd5;
  localparam logic [2:0] ACT_ROW_START   = 3'd6;
  localparam logic [2:0] ACT_COLUMN_AT   = 3'd7;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_RANGE     = 2'd3;

endpackage

### sv/cspb_core.sv
module cspb_core #(
  parameter int MAX_ROWS     = 1024,
  parameter int ROW_CAPACITY = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  input  cspb_pkg::req_t req_i,
  output logic          res_valid_o,
  input  logic          res_ready_i,
  output cspb_pkg::rsp_t res_o
);

  localparam int NW  = $clog2(ROW_CAPACITY + 1);
  localparam int RW  = $clog2(MAX_ROWS);
  localparam int RNW = $clog2(MAX_ROWS + 1);
  localparam int SD  = MAX_ROWS * ROW_CAPACITY;
  localparam int SAW = $clog2(SD);
  localparam int MD  = 2 * SD;
  localparam int MAW = $clog2(MD);
  localparam int PW  = $clog2(MD + 1);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_CLR   = 5'd1;
  localparam logic [4:0] S_I_CRD = 5'd2;
  localparam logic [4:0] S_I_CCK = 5'd3;
  localparam logic [4:0] S_I_SRD = 5'd4;
  localparam logic [4:0] S_I_SCK = 5'd5;
  localparam logic [4:0] S_I_DEC = 5'd6;
  localparam logic [4:0] S_I_HRD = 5'd7;
  localparam logic [4:0] S_I_HWR = 5'd8;
  localparam logic [4:0] S_I_PUT = 5'd9;
  localparam logic [4:0] S_B_ROW = 5'd10;
  localparam logic [4:0] S_B_CNT = 5'd11;
  localparam logic [4:0] S_B_RD  = 5'd12;
  localparam logic [4:0] S_B_CK  = 5'd13;
  localparam logic [4:0] S_O_R1  = 5'd14;
  localparam logic [4:0] S_O_R2  = 5'd15;
  localparam logic [4:0] S_O_R3  = 5'd16;
  localparam logic [4:0] S_O_SRD = 5'd17;
  localparam logic [4:0] S_O_SCK = 5'd18;
  localparam logic [4:0] S_R_RD  = 5'd19;
  localparam logic [4:0] S_R_CK  = 5'd20;
  localparam logic [4:0] S_C_RD  = 5'd21;
  localparam logic [4:0] S_C_CK  = 5'd22;
  localparam logic [4:0] S_DONE  = 5'd23;

  function automatic logic [SAW-1:0] set_addr(logic [31:0] r, logic [31:0] k);
    return SAW'(r * ROW_CAPACITY + k);
  endfunction

  logic [4:0]     state_q, state_d;
  logic           clr_s_q, clr_s_d, clr_d_q, clr_d_d, boot_q, boot_d;
  logic [RNW-1:0] riu_q, riu_d, built_q, built_d, r_q, r_d;
  logic           isdyn_q, isdyn_d;
  logic [9:0]     row_q, row_d, col_q, col_d;
  logic [15:0]    pos_q, pos_d;
  logic [NW-1:0]  k_q, k_d, n_q, n_d, i_q, i_d, j_q, j_d, na_q, na_d, nb_q, nb_d;
  logic [PW-1:0]  p_q, p_d, e_q, e_d, total_q, total_d;
  logic [16:0]    val_q, val_d;
  logic [1:0]     st_q, st_d;

  // memories
  logic [9:0]    scol_mem [SD];
  logic [9:0]    dcol_mem [SD];
  logic [NW-1:0] scnt_mem [MAX_ROWS];
  logic [NW-1:0] dcnt_mem [MAX_ROWS];
  logic [PW-1:0] rs_mem   [MAX_ROWS + 1];
  logic [9:0]    mrg_mem  [MD];

  logic           scol_we, dcol_we, scnt_we, dcnt_we, rs_we, mrg_we;
  logic [SAW-1:0] scol_wa, scol_ra, dcol_wa, dcol_ra;
  logic [9:0]     scol_wd, dcol_wd, scol_rd, dcol_rd, mrg_wd, mrg_rd;
  logic [RW-1:0]  scnt_wa, scnt_ra, dcnt_wa, dcnt_ra;
  logic [NW-1:0]  scnt_wd, dcnt_wd, scnt_rd, dcnt_rd;
  logic [RNW-1:0] rs_wa, rs_ra;
  logic [PW-1:0]  rs_wd, rs_rd;
  logic [MAW-1:0] mrg_wa, mrg_ra;

  // shared comparator
  logic [9:0] cmp_x, cmp_y;
  logic       cmp_lt, cmp_eq;
  assign cmp_lt = cmp_x < cmp_y;
  assign cmp_eq = cmp_x == cmp_y;

  logic [9:0] col_rd;
  assign col_rd = isdyn_q ? dcol_rd : scol_rd;

  logic a_ok, b_ok, take_a, take_b;
  assign a_ok   = i_q < na_q;
  assign b_ok   = j_q < nb_q;
  assign take_a = !b_ok || (a_ok && cmp_lt);
  assign take_b = !take_a && (!a_ok || (!cmp_lt && !cmp_eq));

  always_ff @(posedge clk_i) begin
    if (scol_we) scol_mem[scol_wa] <= scol_wd;
    if (dcol_we) dcol_mem[dcol_wa] <= dcol_wd;
    if (scnt_we) scnt_mem[scnt_wa] <= scnt_wd;
    if (dcnt_we) dcnt_mem[dcnt_wa] <= dcnt_wd;
    if (rs_we)   rs_mem[rs_wa]     <= rs_wd;
    if (mrg_we)  mrg_mem[mrg_wa]   <= mrg_wd;
    scol_rd <= scol_mem[scol_ra];
    dcol_rd <= dcol_mem[dcol_ra];
    scnt_rd <= scnt_mem[scnt_ra];
    dcnt_rd <= dcnt_mem[dcnt_ra];
    rs_rd   <= rs_mem[rs_ra];
    mrg_rd  <= mrg_mem[mrg_ra];
  end

  always_comb begin
    state_d = state_q;
    clr_s_d = clr_s_q;
    clr_d_d = clr_d_q;
    boot_d  = boot_q;
    riu_d   = riu_q;
    built_d = built_q;
    r_d     = r_q;
    isdyn_d = isdyn_q;
    row_d   = row_q;
    col_d   = col_q;
    pos_d   = pos_q;
    k_d     = k_q;
    n_d     = n_q;
    i_d     = i_q;
    j_d     = j_q;
    na_d    = na_q;
    nb_d    = nb_q;
    p_d     = p_q;
    e_d     = e_q;
    total_d = total_q;
    val_d   = val_q;
    st_d    = st_q;
    scol_we = 1'b0; scol_wa = '0; scol_wd = '0; scol_ra = '0;
    dcol_we = 1'b0; dcol_wa = '0; dcol_wd = '0; dcol_ra = '0;
    scnt_we = 1'b0; scnt_wa = '0; scnt_wd = '0; scnt_ra = '0;
    dcnt_we = 1'b0; dcnt_wa = '0; dcnt_wd = '0; dcnt_ra = '0;
    rs_we   = 1'b0; rs_wa   = '0; rs_wd   = '0; rs_ra   = '0;
    mrg_we  = 1'b0; mrg_wa  = '0; mrg_wd  = '0; mrg_ra  = '0;
    cmp_x   = '0;
    cmp_y   = '0;
    req_ready_o = 1'b0;
    res_valid_o = 1'b0;

    case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          row_d   = req_i.row;
          col_d   = req_i.column;
          pos_d   = req_i.position;
          isdyn_d = req_i.action[0];
          val_d   = '0;
          st_d    = cspb_pkg::ST_OK;
          r_d     = '0;
          case (req_i.action)
            cspb_pkg::ACT_ADD_STATIC, cspb_pkg::ACT_ADD_DYNAMIC: begin
              if (32'(req_i.row) >= MAX_ROWS) begin
                st_d    = cspb_pkg::ST_RANGE;
                state_d = S_DONE;
              end else begin
                state_d = S_I_CRD;
              end
            end
            cspb_pkg::ACT_CLR_STATIC: begin
              riu_d   = '0;
              clr_s_d = 1'b1;
              state_d = S_CLR;
            end
            cspb_pkg::ACT_CLR_DYNAMIC: begin
              clr_d_d = 1'b1;
              state_d = S_CLR;
            end
            cspb_pkg::ACT_BUILD: begin
              p_d     = '0;
              state_d = S_B_ROW;
            end
            cspb_pkg::ACT_OFFSET: begin
              if (32'(req_i.row) >= 32'(built_q)) begin
                st_d    = cspb_pkg::ST_RANGE;
                state_d = S_DONE;
              end else begin
                state_d = S_O_R1;
              end
            end
            cspb_pkg::ACT_ROW_START: begin
              if (built_q == '0 || 32'(req_i.row) > 32'(built_q)) begin
                st_d    = cspb_pkg::ST_RANGE;
                state_d = S_DONE;
              end else begin
                state_d = S_R_RD;
              end
            end
            default: begin
              if (built_q == '0 || 32'(req_i.position) >= 32'(total_q)) begin
                st_d    = cspb_pkg::ST_RANGE;
                state_d = S_DONE;
              end else begin
                state_d = S_C_RD;
              end
            end
          endcase
        end
      end
      S_CLR: begin
        scnt_we = clr_s_q;
        dcnt_we = clr_d_q;
        scnt_wa = RW'(r_q);
        dcnt_wa = RW'(r_q);
        r_d     = r_q + 1'b1;
        if (r_q == RNW'(MAX_ROWS - 1)) begin
          clr_s_d = 1'b0;
          clr_d_d = 1'b0;
          boot_d  = 1'b0;
          state_d = boot_q ? S_IDLE : S_DONE;
        end
      end
      S_I_CRD: begin
        scnt_ra = RW'(row_q);
        dcnt_ra = RW'(row_q);
        state_d = S_I_CCK;
      end
      S_I_CCK: begin
        n_d = isdyn_q ? dcnt_rd : scnt_rd;
        k_d = '0;
        if (!isdyn_q && (32'(row_q) + 1) > 32'(riu_q)) riu_d = RNW'(32'(row_q) + 1);
        state_d = S_I_SRD;
      end
      S_I_SRD: begin
        if (k_q < n_q) begin
          scol_ra = set_addr(32'(row_q), 32'(k_q));
          dcol_ra = scol_ra;
          state_d = S_I_SCK;
        end else begin
          state_d = S_I_DEC;
        end
      end
      S_I_SCK: begin
        cmp_x = col_rd;
        cmp_y = col_q;
        if (cmp_lt) begin
          k_d     = k_q + 1'b1;
          state_d = S_I_SRD;
        end else if (cmp_eq) begin
          val_d   = 17'(n_q);
          state_d = S_DONE;
        end else begin
          state_d = S_I_DEC;
        end
      end
      S_I_DEC: begin
        if (32'(n_q) >= ROW_CAPACITY) begin
          st_d    = cspb_pkg::ST_FULL;
          state_d = S_DONE;
        end else begin
          i_d     = n_q;
          state_d = S_I_HRD;
        end
      end
      S_I_HRD: begin
        if (i_q > k_q) begin
          scol_ra = set_addr(32'(row_q), 32'(i_q) - 1);
          dcol_ra = scol_ra;
          state_d = S_I_HWR;
        end else begin
          state_d = S_I_PUT;
        end
      end
      S_I_HWR: begin
        // shift one entry up to open the slot
        scol_we = !isdyn_q;
        dcol_we = isdyn_q;
        scol_wa = set_addr(32'(row_q), 32'(i_q));
        dcol_wa = scol_wa;
        scol_wd = col_rd;
        dcol_wd = col_rd;
        i_d     = i_q - 1'b1;
        state_d = S_I_HRD;
      end
      S_I_PUT: begin
        scol_we = !isdyn_q;
        dcol_we = isdyn_q;
        scol_wa = set_addr(32'(row_q), 32'(k_q));
        dcol_wa = scol_wa;
        scol_wd = col_q;
        dcol_wd = col_q;
        scnt_we = !isdyn_q;
        dcnt_we = isdyn_q;
        scnt_wa = RW'(row_q);
        dcnt_wa = RW'(row_q);
        scnt_wd = n_q + 1'b1;
        dcnt_wd = n_q + 1'b1;
        val_d   = 17'(n_q + 1'b1);
        state_d = S_DONE;
      end
      S_B_ROW: begin
        if (r_q < riu_q) begin
          scnt_ra = RW'(r_q);
          dcnt_ra = RW'(r_q);
          state_d = S_B_CNT;
        end else begin
          rs_we   = 1'b1;
          rs_wa   = riu_q;
          rs_wd   = p_q;
          built_d = riu_q;
          total_d = p_q;
          val_d   = 17'(p_q);
          state_d = S_DONE;
        end
      end
      S_B_CNT: begin
        na_d    = scnt_rd;
        nb_d    = dcnt_rd;
        i_d     = '0;
        j_d     = '0;
        rs_we   = 1'b1;
        rs_wa   = r_q;
        rs_wd   = p_q;
        state_d = S_B_RD;
      end
      S_B_RD: begin
        if (a_ok || b_ok) begin
          scol_ra = set_addr(32'(r_q), 32'(i_q));
          dcol_ra = set_addr(32'(r_q), 32'(j_q));
          state_d = S_B_CK;
        end else begin
          r_d     = r_q + 1'b1;
          state_d = S_B_ROW;
        end
      end
      S_B_CK: begin
        // equal heads emit once and advance both sets
        cmp_x   = scol_rd;
        cmp_y   = dcol_rd;
        mrg_we  = 1'b1;
        mrg_wa  = MAW'(p_q);
        mrg_wd  = take_b ? dcol_rd : scol_rd;
        if (!take_b) i_d = i_q + 1'b1;
        if (!take_a) j_d = j_q + 1'b1;
        p_d     = p_q + 1'b1;
        state_d = S_B_RD;
      end
      S_O_R1: begin
        rs_ra   = RNW'(row_q);
        state_d = S_O_R2;
      end
      S_O_R2: begin
        p_d     = rs_rd;
        rs_ra   = RNW'(row_q) + 1'b1;
        state_d = S_O_R3;
      end
      S_O_R3: begin
        e_d     = rs_rd;
        state_d = S_O_SRD;
      end
      S_O_SRD: begin
        if (p_q < e_q) begin
          mrg_ra  = MAW'(p_q);
          state_d = S_O_SCK;
        end else begin
          st_d    = cspb_pkg::ST_NOT_FOUND;
          state_d = S_DONE;
        end
      end
      S_O_SCK: begin
        cmp_x = mrg_rd;
        cmp_y = col_q;
        if (cmp_eq) begin
          val_d   = 17'(p_q);
          state_d = S_DONE;
        end else begin
          p_d     = p_q + 1'b1;
          state_d = S_O_SRD;
        end
      end
      S_R_RD: begin
        rs_ra   = RNW'(row_q);
        state_d = S_R_CK;
      end
      S_R_CK: begin
        val_d   = 17'(rs_rd);
        state_d = S_DONE;
      end
      S_C_RD: begin
        mrg_ra  = MAW'(pos_q);
        state_d = S_C_CK;
      end
      S_C_CK: begin
        val_d   = 17'(mrg_rd);
        state_d = S_DONE;
      end
      S_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign res_o.value       = val_q;
  assign res_o.matrix_size = 11'(built_q);
  assign res_o.status      = st_q;

  // reset starts with a sweep of both count stores
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      clr_s_q <= 1'b1;
      clr_d_q <= 1'b1;
      boot_q  <= 1'b1;
      riu_q   <= '0;
      built_q <= '0;
      r_q     <= '0;
    end else begin
      state_q <= state_d;
      clr_s_q <= clr_s_d;
      clr_d_q <= clr_d_d;
      boot_q  <= boot_d;
      riu_q   <= riu_d;
      built_q <= built_d;
      r_q     <= r_d;
    end
  end

  always_ff @(posedge clk_i) begin
    isdyn_q <= isdyn_d;
    row_q   <= row_d;
    col_q   <= col_d;
    pos_q   <= pos_d;
    k_q     <= k_d;
    n_q     <= n_d;
    i_q     <= i_d;
    j_q     <= j_d;
    na_q    <= na_d;
    nb_q    <= nb_d;
    p_q     <= p_d;
    e_q     <= e_d;
    total_q <= total_d;
    val_q   <= val_d;
    st_q    <= st_d;
  end

endmodule

### sv/sparse_csr_pattern_builder_unit.sv
// channel   valid        ready        payload
// request   in_valid_i   in_ready_o   in_req_i  (cspb_pkg::req_t)
// result    out_valid_o  out_ready_i  out_rsp_o (cspb_pkg::rsp_t)
//
// one request at a time; each memory read is registered, so an insert walks the row entry
// by entry, an offset lookup scans the row's merged entries, a build walks each row and each
// merged entry, and a clear sweeps the counts of all MAX_ROWS rows
// after reset a sweep zeroes the row counts of all MAX_ROWS rows, in_ready_o stays low
// a finished result sits in the output register, the next request is taken meanwhile
module sparse_csr_pattern_builder_unit #(
  parameter int MAX_ROWS     = 1024,
  parameter int ROW_CAPACITY = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  cspb_pkg::req_t in_req_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output cspb_pkg::rsp_t out_rsp_o
);

  logic           res_valid, res_ready;
  cspb_pkg::rsp_t res;
  logic           out_valid_q;
  cspb_pkg::rsp_t out_rsp_q;

  cspb_core #(
    .MAX_ROWS     (MAX_ROWS),
    .ROW_CAPACITY (ROW_CAPACITY)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_valid_i),
    .req_ready_o (in_ready_o),
    .req_i       (in_req_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) out_rsp_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule
